// ===== design/lsp_pkg.sv =====
// Shared types and constants for the line splitter.
package lsp_pkg;

	localparam int MARKER_MAX = 8;

	// Register indexes; register i lies at byte address 8*i.
	localparam logic [1:0] CFG_SEPARATOR     = 2'd0;
	localparam logic [1:0] CFG_MARKER_BYTES  = 2'd1;
	localparam logic [1:0] CFG_MARKER_LENGTH = 2'd2;

	localparam logic [7:0]  SEPARATOR_RESET = 8'd10;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       empty_line;
		logic       last;
	} beat_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

endpackage

// ===== design/line_splitter_with_truncation.sv =====
// Line splitter: bytes in, completed lines out one byte per beat.
//
// Bytes other than the separator are written into a line RAM of BUFFER_BYTES entries, one
// byte per cycle. A separator ends the line: an empty line gives one beat with tuser set,
// otherwise the block stops taking input and reads the line back through the single RAM
// read port, one byte per cycle. Results leave through a two-entry queue, so output
// stalls hold the readout and, once it is done, the input. When an unfinished line fills
// the RAM, the current marker is captured into a register and the line continues after it;
// readout takes the marker positions from that register instead of the RAM.
module line_splitter_with_truncation #(
	parameter int BUFFER_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] line_byte
	output logic        m_tlast,
	output logic        m_tuser,   // [0] empty_line
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import lsp_pkg::*;

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int FW = $clog2(BUFFER_BYTES + 1);

	// Configuration registers.
	logic [7:0]  separator_q;
	logic [63:0] marker_bytes_q;
	logic [3:0]  marker_length_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			separator_q     <= SEPARATOR_RESET;
			marker_bytes_q  <= '0;
			marker_length_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:3])
				CFG_SEPARATOR:     separator_q     <= pwdata[7:0];
				CFG_MARKER_BYTES:  marker_bytes_q  <= pwdata;
				CFG_MARKER_LENGTH: marker_length_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			CFG_SEPARATOR:     prdata = {56'd0, separator_q};
			CFG_MARKER_BYTES:  prdata = marker_bytes_q;
			CFG_MARKER_LENGTH: prdata = {60'd0, marker_length_q};
			default:           prdata = '0;
		endcase
	end

	// Line state.
	state_t         state_q, state_d;
	logic [FW-1:0]  fill_q;
	logic [AW-1:0]  rd_idx_q;
	logic [63:0]    snap_q;
	logic [3:0]     snap_len_q;
	logic [3:0]     marker_len;

	// Read pipeline stage.
	logic           s1_valid_s1;
	logic           s1_empty_s1;
	logic           s1_last_s1;
	logic           s1_mark_s1;
	logic [2:0]     s1_sel_s1;

	logic           in_acc;
	logic           is_sep;
	logic           pop;
	logic [1:0]     fifo_count;
	logic           can_issue;
	logic           rd_issue;
	logic           rd_last;
	logic           ram_we;
	logic [7:0]     ram_rdata;
	beat_t          push_beat;
	beat_t          head_beat;
	logic           fifo_valid;

	assign marker_len = (marker_length_q > 4'(MARKER_MAX)) ? 4'(MARKER_MAX) : marker_length_q;

	assign pop = m_tvalid && m_tready;
	// Keep queue plus in-flight read at no more than two after this cycle.
	assign can_issue = ({1'b0, fifo_count} + {2'b0, s1_valid_s1}) <= (3'd1 + {2'b0, pop});

	assign in_acc  = s_tvalid && s_tready;
	assign is_sep  = (s_tdata == separator_q);
	assign ram_we  = in_acc && !is_sep;
	assign rd_last = (FW'(rd_idx_q) + FW'(1)) == fill_q;

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		rd_issue = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = can_issue;
				if (in_acc && is_sep && (fill_q != '0)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				rd_issue = can_issue;
				if (can_issue && rd_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			rd_idx_q    <= '0;
			snap_len_q  <= '0;
			s1_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			s1_valid_s1 <= rd_issue || (in_acc && is_sep && (fill_q == '0));
			if (in_acc && is_sep) begin
				rd_idx_q <= '0;
			end else if (rd_issue) begin
				rd_idx_q <= rd_idx_q + AW'(1);
				if (rd_last) begin
					fill_q     <= '0;
					snap_len_q <= '0;
				end
			end
			if (ram_we) begin
				if (fill_q == FW'(BUFFER_BYTES - 1)) begin
					// Line overflowed: restart it from the marker.
					fill_q     <= FW'(marker_len);
					snap_len_q <= marker_len;
				end else begin
					fill_q <= fill_q + FW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we && (fill_q == FW'(BUFFER_BYTES - 1))) begin
			snap_q <= marker_bytes_q;
		end
		s1_empty_s1 <= !rd_issue;
		s1_last_s1  <= rd_issue ? rd_last : 1'b1;
		s1_mark_s1  <= rd_idx_q < AW'(snap_len_q);
		s1_sel_s1   <= rd_idx_q[2:0];
	end

	lsp_line_ram #(
		.DEPTH (BUFFER_BYTES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[AW-1:0]),
		.wdata (s_tdata),
		.re    (rd_issue),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		push_beat.empty_line = s1_empty_s1;
		push_beat.last       = s1_last_s1;
		if (s1_empty_s1) begin
			push_beat.line_byte = 8'd0;
		end else if (s1_mark_s1) begin
			push_beat.line_byte = snap_q[{s1_sel_s1, 3'b000} +: 8];
		end else begin
			push_beat.line_byte = ram_rdata;
		end
	end

	lsp_out_fifo u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_valid_s1),
		.push_beat (push_beat),
		.pop       (pop),
		.valid     (fifo_valid),
		.head      (head_beat),
		.count     (fifo_count)
	);

	assign m_tvalid = fifo_valid;
	assign m_tdata  = head_beat.line_byte;
	assign m_tlast  = head_beat.last;
	assign m_tuser  = head_beat.empty_line;

	// No byte is stored while a line is being read back.
	a_no_write_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> !ram_we)
		else $error("line RAM written during readout");

	// A separator that ends a non-empty line starts the readout.
	a_sep_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && is_sep && (fill_q != '0)) |=> (state_q == ST_DRAIN))
		else $error("separator did not start readout");

	// The fill level never reaches the RAM size.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < FW'(BUFFER_BYTES))
		else $error("fill count out of range");

	// An empty-line beat is a single zero beat.
	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == 8'd0)))
		else $error("malformed empty-line beat");
endmodule

// ===== design/lsp_line_ram.sv =====
// Line store: single write port, single read port with registered read data.
module lsp_line_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== design/lsp_out_fifo.sv =====
// Two-entry output queue that decouples the read pipeline from the result stream.
module lsp_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lsp_pkg::beat_t    push_beat,
	input  logic              pop,
	output logic              valid,
	output lsp_pkg::beat_t    head,
	output logic [1:0]        count
);
	import lsp_pkg::*;

	beat_t      entry_q [2];
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_beat;
		end
	end

	assign valid = (count_q != 2'd0);
	assign head  = entry_q[rd_ptr_q];
	assign count = count_q;
endmodule
